### rtl/core/fret_rate_point_cloud_average_macros.svh
// ----------------------------------------------------------------------------
// FRET rate average: assertion macros
// Clocked assertion helpers shared by the block's RTL files.
// ----------------------------------------------------------------------------
`ifndef FRET_RATE_POINT_CLOUD_AVERAGE_MACROS_SVH
`define FRET_RATE_POINT_CLOUD_AVERAGE_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define FRPCA_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("frpca assertion failed");

// assertion on the block clock and reset
`define FRPCA_ASSERT(lbl, prop) `FRPCA_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

### rtl/core/frpca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FRET rate average package
// Types, codes and constants shared by the block's modules.
// ----------------------------------------------------------------------------
package frpca_pkg;

  // item commands
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_FRAME = 2'd2
  } cmd_e;

  // register indexes
  typedef enum logic [2:0] {
    REG_R0_SQUARED   = 3'd0,
    REG_KAPPA2       = 3'd1,
    REG_INV_TAU0     = 3'd2,
    REG_MIN_DISTANCE = 3'd3,
    REG_LOAD_STRIDE  = 3'd4
  } reg_idx_e;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  localparam logic [18:0] KAPPA2_MAX = 19'd262144;
  localparam logic [62:0] RATE_MAX   = {63{1'b1}};
  localparam int unsigned DIV_CELLS  = 64;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_SQ, S_DIVQ, S_DIVW, S_MUL, S_POST, S_FDIVQ, S_FDIVW
  } state_e;

  // multiply operation of the term pipeline
  typedef enum logic [1:0] {
    OP_QQ, OP_Q3, OP_KF, OP_FINAL
  } mop_e;

  // beat handed from one divider cell to the next
  typedef struct packed {
    logic        v;
    logic        sat;
    logic [63:0] r;
    logic [63:0] ql;
    logic [63:0] d;
  } div_stage_t;

  typedef struct packed {
    logic        v;
    logic [63:0] q;
  } div_rsp_t;

endpackage

### rtl/core/frpca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module frpca_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/frpca_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shifts in one dividend bit, emits one quotient bit.
// ----------------------------------------------------------------------------
module frpca_div_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  frpca_pkg::div_stage_t in_i,
  output frpca_pkg::div_stage_t out_o
);
  import frpca_pkg::*;

  logic [64:0] rr;
  logic        ge;
  logic [64:0] diff;
  logic        v_q;
  logic        sat_q;
  logic [63:0] r_q, ql_q, d_q;

  // partial remainder with the next dividend bit
  always_comb begin
    rr   = {in_i.r, in_i.ql[63]};
    ge   = rr >= {1'b0, in_i.d};
    diff = rr - {1'b0, in_i.d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= in_i.v;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= in_i.sat;
    d_q   <= in_i.d;
    r_q   <= ge ? diff[63:0] : rr[63:0];
    ql_q  <= {in_i.ql[62:0], ge};
  end

  assign out_o = '{v: v_q, sat: sat_q, r: r_q, ql: ql_q, d: d_q};

endmodule

### rtl/core/frpca_div_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider chain
// 128/64 divider as a row of 64 cells, one quotient bit per cell, saturating.
// ----------------------------------------------------------------------------
module frpca_div_chain (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  frpca_pkg::div_stage_t req_i,
  output frpca_pkg::div_rsp_t   rsp_o
);
  import frpca_pkg::*;

  div_stage_t stg [DIV_CELLS+1];

  assign stg[0] = req_i;

  for (genvar c = 0; c < DIV_CELLS; c++) begin : g_cell
    frpca_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .in_i  (stg[c]),
      .out_o (stg[c+1])
    );
  end

  // saturated quotient when the high word already reaches the divisor
  assign rsp_o.v = stg[DIV_CELLS].v;
  assign rsp_o.q = stg[DIV_CELLS].sat ? {64{1'b1}} : stg[DIV_CELLS].ql;

endmodule

### rtl/core/fret_rate_point_cloud_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FRET rate point cloud average
// Stores thinned acceptor points; each donor frame gives the mean Forster rate.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// command   in         start / busy         command_i, x/y/z_coord_i
// result    out        strobe (one cycle)   rate_o, status_o
// config    in         cfg_we_i             cfg_idx_i, cfg_data_i
//
// Clear and load never raise busy. A frame with points works through each
// point in turn: a RAM read, three squares on the shared 32x32 multiplier,
// a pass through the 64-cell divider chain and three multiplies of six
// partial products each; then one more multiply and divide.
// An empty frame answers in the next cycle. Reset clears control state only;
// the point store needs no clearing. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "fret_rate_point_cloud_average_macros.svh"

module fret_rate_point_cloud_average #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic signed [31:0] z_coord_i,
  output logic        strobe,
  output logic [62:0] rate_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import frpca_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = 64 + CW;

  // configuration
  logic [31:0] r0_sq_q, inv_tau0_q;
  logic [18:0] kappa2_q;
  logic [30:0] min_dist_q;
  logic [15:0] stride_q;
  logic [61:0] floor2_q;
  logic [19:0] kf_q;

  // control
  state_e        state_q, state_d;
  mop_e          mop_q;
  logic [CW-1:0] count_q;
  logic [15:0]   phase_q;
  logic          dropped_q;
  logic          strobe_q;
  logic [AW-1:0] idx_q;
  logic [1:0]    sq_cnt_q;
  logic [2:0]    part_q;

  // datapath
  logic [31:0]   bx_q, by_q, bz_q;
  logic [65:0]   d2_q;
  logic [63:0]   q_q, qbase_q;
  logic [127:0]  acc_q;
  logic [SW-1:0] sum_q;
  logic [62:0]   rate_q;
  logic [1:0]    status_q;

  logic          accept;
  cmd_e          cmd;
  logic [31:0]   bxi, byi, bzi;
  logic [31:0]   ram_x, ram_y, ram_z;
  logic          ram_we, ram_re;
  logic          keep_pt;
  logic [15:0]   stride_eff, phase_d;
  logic [16:0]   phase_inc;
  logic          last_pt;
  logic          full_load;

  assign accept = start && !busy;
  assign cmd    = cmd_e'(command_i);
  // biased coordinates: signed to offset binary
  assign bxi    = {~x_coord_i[31], x_coord_i[30:0]};
  assign byi    = {~y_coord_i[31], y_coord_i[30:0]};
  assign bzi    = {~z_coord_i[31], z_coord_i[30:0]};

  // stride thinning
  always_comb begin
    stride_eff = (stride_q == 16'd0) ? 16'd1 : stride_q;
    phase_inc  = {1'b0, phase_q} + 17'd1;
    phase_d    = (phase_inc >= {1'b0, stride_eff}) ? 16'd0 : phase_inc[15:0];
    keep_pt    = (phase_q == 16'd0) && (count_q < CW'(MAX_POINTS));
    ram_we     = accept && (cmd == CMD_LOAD) && keep_pt;
    last_pt    = (CW'(idx_q) + CW'(1)) == count_q;
  end

  // point store
  frpca_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk_i, .we_i(ram_we), .waddr_i(count_q[AW-1:0]), .wdata_i(bxi),
    .re_i(ram_re), .raddr_i(idx_q), .rdata_o(ram_x)
  );
  frpca_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk_i, .we_i(ram_we), .waddr_i(count_q[AW-1:0]), .wdata_i(byi),
    .re_i(ram_re), .raddr_i(idx_q), .rdata_o(ram_y)
  );
  frpca_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_z (
    .clk_i, .we_i(ram_we), .waddr_i(count_q[AW-1:0]), .wdata_i(bzi),
    .re_i(ram_re), .raddr_i(idx_q), .rdata_o(ram_z)
  );

  // shared 32x32 multiplier and its operands
  logic [31:0]  mul_a, mul_b, dsel_a, dsel_b;
  logic [63:0]  mul_p;
  logic [95:0]  op_a;
  logic [63:0]  op_b;
  logic [1:0]   pi, sh;
  logic [127:0] part_sh;

  always_comb begin
    unique case (sq_cnt_q)
      2'd0:    begin dsel_a = bx_q; dsel_b = ram_x; end
      2'd1:    begin dsel_a = by_q; dsel_b = ram_y; end
      default: begin dsel_a = bz_q; dsel_b = ram_z; end
    endcase
    unique case (mop_q)
      OP_QQ, OP_Q3: begin op_a = {32'd0, q_q}; op_b = qbase_q; end
      OP_KF:        begin op_a = {32'd0, q_q}; op_b = {44'd0, kf_q}; end
      default:      begin op_a = 96'(sum_q);   op_b = {32'd0, inv_tau0_q}; end
    endcase
    pi = part_q[2:1];
    sh = pi + {1'b0, part_q[0]};
    if (state_q == S_SQ) begin
      mul_a = (dsel_a > dsel_b) ? dsel_a - dsel_b : dsel_b - dsel_a;
      mul_b = mul_a;
    end else begin
      unique case (pi)
        2'd0:    mul_a = op_a[31:0];
        2'd1:    mul_a = op_a[63:32];
        default: mul_a = op_a[95:64];
      endcase
      mul_b = part_q[0] ? op_b[63:32] : op_b[31:0];
    end
    mul_p = mul_a * mul_b;
    unique case (sh)
      2'd0:    part_sh = {64'd0, mul_p};
      2'd1:    part_sh = {32'd0, mul_p, 32'd0};
      2'd2:    part_sh = {mul_p, 64'd0};
      default: part_sh = {mul_p[31:0], 96'd0};
    endcase
  end

  // distance floor and divider requests
  logic [63:0] d2_sat, d2_eff;
  logic [63:0] sat32, sat17;
  div_stage_t  dreq;
  div_rsp_t    drsp;

  always_comb begin
    d2_sat = (d2_q[65:64] != 2'd0) ? {64{1'b1}} : d2_q[63:0];
    d2_eff = (d2_sat < {2'd0, floor2_q}) ? {2'd0, floor2_q} : d2_sat;
    sat32  = (acc_q[127:96] != 32'd0) ? {64{1'b1}} : acc_q[95:32];
    sat17  = (acc_q[127:81] != 47'd0) ? {64{1'b1}} : acc_q[80:17];
    dreq.v = (state_q == S_DIVQ) || (state_q == S_FDIVQ);
    if (state_q == S_FDIVQ) begin
      dreq.r  = acc_q[127:64];
      dreq.ql = acc_q[63:0];
      dreq.d  = 64'({count_q, 16'd0});
    end else begin
      dreq.r  = {48'd0, r0_sq_q[31:16]};
      dreq.ql = {r0_sq_q[15:0], 48'd0};
      dreq.d  = d2_eff;
    end
    dreq.sat = dreq.r >= dreq.d;
  end

  frpca_div_chain u_div (
    .clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (cmd == CMD_FRAME) && (count_q != '0)) state_d = S_READ;
      end
      S_READ:  state_d = S_SQ;
      S_SQ:    if (sq_cnt_q == 2'd2) state_d = S_DIVQ;
      S_DIVQ:  state_d = S_DIVW;
      S_DIVW:  if (drsp.v) state_d = S_MUL;
      S_MUL:   if (part_q == 3'd5) state_d = S_POST;
      S_POST: begin
        unique case (mop_q)
          OP_QQ, OP_Q3: state_d = S_MUL;
          OP_KF:        state_d = last_pt ? S_MUL : S_READ;
          default:      state_d = S_FDIVQ;
        endcase
      end
      S_FDIVQ: state_d = S_FDIVW;
      S_FDIVW: if (drsp.v) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy   = state_q != S_IDLE;
    ram_re = state_q == S_READ;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mop_q      <= OP_QQ;
      count_q    <= '0;
      phase_q    <= 16'd0;
      dropped_q  <= 1'b0;
      strobe_q   <= 1'b0;
      idx_q      <= '0;
      sq_cnt_q   <= 2'd0;
      part_q     <= 3'd0;
      r0_sq_q    <= 32'd0;
      kappa2_q   <= 19'd43691;
      inv_tau0_q <= 32'd65536;
      min_dist_q <= 31'd0;
      stride_q   <= 16'd1;
    end else begin
      state_q  <= state_d;
      strobe_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_R0_SQUARED:   r0_sq_q    <= cfg_data_i;
          REG_KAPPA2:       kappa2_q   <= cfg_data_i[18:0];
          REG_INV_TAU0:     inv_tau0_q <= cfg_data_i;
          REG_MIN_DISTANCE: min_dist_q <= cfg_data_i[30:0];
          REG_LOAD_STRIDE:  stride_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_CLEAR: begin
                count_q   <= '0;
                phase_q   <= 16'd0;
                dropped_q <= 1'b0;
              end
              CMD_LOAD: begin
                if (keep_pt) count_q <= count_q + CW'(1);
                else if (phase_q == 16'd0) dropped_q <= 1'b1;
                phase_q <= phase_d;
              end
              CMD_FRAME: begin
                idx_q <= '0;
                if (count_q == '0) strobe_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_READ: sq_cnt_q <= 2'd0;
        S_SQ:   sq_cnt_q <= sq_cnt_q + 2'd1;
        S_DIVW: begin
          mop_q  <= OP_QQ;
          part_q <= 3'd0;
        end
        S_MUL:  part_q <= part_q + 3'd1;
        S_POST: begin
          part_q <= 3'd0;
          unique case (mop_q)
            OP_QQ: mop_q <= OP_Q3;
            OP_Q3: mop_q <= OP_KF;
            OP_KF: begin
              if (last_pt) mop_q <= OP_FINAL;
              else idx_q <= idx_q + AW'(1);
            end
            default: ;
          endcase
        end
        S_FDIVW: if (drsp.v) strobe_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    floor2_q <= (min_dist_q == 31'd0) ? 62'd1 : min_dist_q * min_dist_q;
    kf_q     <= (kappa2_q > KAPPA2_MAX) ? 20'd786432
                : ({1'b0, kappa2_q} + {kappa2_q, 1'b0});
    unique case (state_q)
      S_IDLE: begin
        if (accept && (cmd == CMD_FRAME)) begin
          bx_q     <= bxi;
          by_q     <= byi;
          bz_q     <= bzi;
          sum_q    <= '0;
          rate_q   <= 63'd0;
          status_q <= ST_EMPTY;
        end
      end
      S_READ: d2_q <= 66'd0;
      S_SQ:   d2_q <= d2_q + {2'd0, mul_p};
      S_DIVW: begin
        q_q     <= drsp.q;
        qbase_q <= drsp.q;
        acc_q   <= 128'd0;
      end
      S_MUL:  acc_q <= acc_q + part_sh;
      S_POST: begin
        unique case (mop_q)
          OP_QQ, OP_Q3: begin
            q_q   <= sat32;
            acc_q <= 128'd0;
          end
          OP_KF: begin
            sum_q <= sum_q + SW'(sat17);
            acc_q <= 128'd0;
          end
          default: ;
        endcase
      end
      S_FDIVW: begin
        if (drsp.v) begin
          rate_q   <= drsp.q[63] ? RATE_MAX : drsp.q[62:0];
          status_q <= dropped_q ? ST_DROP : ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign strobe   = strobe_q;
  assign rate_o   = rate_q;
  assign status_o = status_q;

  // checks
  assign full_load = accept && (cmd == CMD_LOAD) && (phase_q == 16'd0)
                     && (count_q == CW'(MAX_POINTS));

  `FRPCA_ASSERT(a_strobe_idle, strobe_q |-> (state_q == S_IDLE))
  `FRPCA_ASSERT(a_count_bound, count_q <= CW'(MAX_POINTS))
  `FRPCA_ASSERT(a_div_rsp_wait, drsp.v |-> (state_q == S_DIVW || state_q == S_FDIVW))
  `FRPCA_ASSERT(a_drop_flag, full_load |=> dropped_q)

endmodule
